FILE: rtl/core/sgts_pkg.sv
// ----------------------------------------------------------------------------
// Stepper current gain/torque selector package
// Status codes, gain codes and the fixed thresholds used by the selector.
// ----------------------------------------------------------------------------
package sgts_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_RES   = 2'd1,
    ST_RANGE    = 2'd2,
    ST_ZERO_TRQ = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    GAIN_5  = 2'd0,
    GAIN_10 = 2'd1,
    GAIN_20 = 2'd2,
    GAIN_40 = 2'd3
  } gain_t;

  // The full scale for gain g is 701250000 / (256 * g * r). Folding the
  // constant part first gives floor(C_g / r) with the constants below.
  localparam logic [19:0] FS_GAIN_40 = 20'd68481;
  localparam logic [19:0] FS_GAIN_20 = 20'd136962;
  localparam logic [19:0] FS_GAIN_10 = 20'd273925;
  localparam logic [19:0] FS_GAIN_5  = 20'd547851;

  // Range check bounds: upper is floor(547851 / r), lower is floor(268 / r).
  localparam logic [19:0] RANGE_UPPER = FS_GAIN_5;
  localparam logic [19:0] RANGE_LOWER = 20'd268;

  // Torque divisor.
  localparam logic [29:0] TORQUE_DIV = 30'd2750000;

  localparam int unsigned QUO_W = 8;
  localparam int unsigned REM_W = 30;

  function automatic logic [19:0] full_scale(input gain_t g);
    logic [19:0] fs;
    begin
      unique case (g)
        GAIN_40: fs = FS_GAIN_40;
        GAIN_20: fs = FS_GAIN_20;
        GAIN_10: fs = FS_GAIN_10;
        GAIN_5:  fs = FS_GAIN_5;
        default: fs = FS_GAIN_5;
      endcase
      return fs;
    end
  endfunction

endpackage

FILE: rtl/core/stepper_current_gain_torque_select.sv
// ----------------------------------------------------------------------------
// Stepper current gain and torque selector
// Picks a sense-amplifier gain and an 8-bit torque code for a requested
// winding current, using the sense resistor value held in a register.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ---------------------------------
//  in        sink       in_valid / in_stall    current_request_ma
//  out       source     out_valid / out_stall  status, gain_code, torque_code
//  cfg       APB slave  psel/penable/pready    paddr, pwdata, prdata
//
// A request passes through the current-times-resistor product, the range
// check, up to four gain trials and eight steps of the shared restoring
// subtractor for the torque.
// in_stall stays high while a request is in work and while its result waits.
// A stalled output holds its result; the next request is taken after it moves.
// Reset is synchronous and clears the resistor register to zero.
module stepper_current_gain_torque_select
  import sgts_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] current_request_ma,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [1:0]  gain_code,
  output logic [7:0]  torque_code,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_CHECK,
    S_SEARCH,
    S_DIV,
    S_DONE
  } state_t;

  state_t             state;
  logic [15:0]        sense_res;
  logic [15:0]        cur;
  logic [31:0]        prod;
  logic [32:0]        prod_plus;
  gain_t              gain;
  logic [REM_W-1:0]   rem;
  logic [QUO_W-1:0]   quo;
  logic [2:0]         bit_idx;
  status_t            res_status;

  logic [REM_W-1:0]   div_shift;
  logic [REM_W:0]     diff;
  logic [31:0]        cur_x_res;
  logic [34:0]        prod_x5;
  logic [45:0]        scaled;
  logic               cfg_write;
  logic               in_xfer;

  assign pready    = 1'b1;
  assign prdata    = {16'd0, sense_res};
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
  assign in_stall  = (state != S_IDLE) || out_valid;
  assign in_xfer   = in_valid && !in_stall;

  assign cur_x_res = 32'(cur) * 32'(sense_res);

  // Shared subtractor: one restoring division step per cycle.
  assign div_shift = TORQUE_DIV << bit_idx;
  assign diff      = {1'b0, rem} - {1'b0, div_shift};

  // gain * 256 * p = (5 * p) << (8 + gain code).
  assign prod_x5 = {3'd0, prod} + {1'b0, prod, 2'b00};
  always_comb begin
    case (gain)
      GAIN_40: scaled = {11'd0, prod_x5} << 11;
      GAIN_20: scaled = {11'd0, prod_x5} << 10;
      GAIN_10: scaled = {11'd0, prod_x5} << 9;
      default: scaled = {11'd0, prod_x5} << 8;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sense_res <= '0;
    end else if (cfg_write) begin
      sense_res <= pwdata[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            cur        <= current_request_ma;
            res_status <= ST_OK;
            gain       <= GAIN_40;
            quo        <= '0;
            state      <= S_MUL;
          end
        end
        S_MUL: begin
          prod      <= cur_x_res;
          prod_plus <= 33'(cur_x_res) + 33'(sense_res);
          state     <= S_CHECK;
        end
        S_CHECK: begin
          // cur > floor(N/r) iff cur*r > N; cur < floor(N/r) iff (cur+1)*r <= N.
          if (sense_res == 16'd0) begin
            res_status <= ST_NO_RES;
            state      <= S_DONE;
          end else if (prod > 32'(RANGE_UPPER) || prod_plus <= 33'(RANGE_LOWER)) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            state <= S_SEARCH;
          end
        end
        S_SEARCH: begin
          if (prod_plus <= 33'(full_scale(gain))) begin
            // The chosen gain bounds the dividend below 255 * divisor.
            rem     <= scaled[REM_W-1:0];
            bit_idx <= 3'(QUO_W - 1);
            state   <= S_DIV;
          end else if (gain == GAIN_5) begin
            res_status <= ST_RANGE;
            state      <= S_DONE;
          end else begin
            gain <= gain_t'(gain - 2'd1);
          end
        end
        S_DIV: begin
          if (!diff[REM_W]) begin
            rem <= diff[REM_W-1:0];
          end
          quo <= {quo[QUO_W-2:0], ~diff[REM_W]};
          if (bit_idx == 3'd0) begin
            state <= S_DONE;
          end else begin
            bit_idx <= bit_idx - 3'd1;
          end
        end
        S_DONE: begin
          // The output register is empty here, since the input waits for it.
          out_valid <= 1'b1;
          if (res_status == ST_OK) begin
            status      <= (quo == '0) ? ST_ZERO_TRQ : ST_OK;
            gain_code   <= gain;
            torque_code <= quo;
          end else begin
            status      <= res_status;
            gain_code   <= GAIN_5;
            torque_code <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> torque_code != 8'd0)
    else $error("ok result with zero torque");

  a_err_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_RES || status == ST_RANGE)
      |-> gain_code == GAIN_5 && torque_code == 8'd0)
    else $error("error result carries gain or torque");

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> in_stall)
    else $error("input taken while a request is in work");

  a_torque_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> torque_code != 8'hFF)
    else $error("torque above its bound");

endmodule
